/* src/pct_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pct_pkg
// Shared types, codes and constants of the pulse count ASCII line formatter.
// ----------------------------------------------------------------------------
package pct_pkg;

   // input op codes
   localparam logic OP_RAW  = 1'b0;
   localparam logic OP_TEMP = 1'b1;

   typedef struct packed {
      logic        op;
      logic [31:0] pulse_count;
   } pct_req_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last;
   } pct_rsp_type;

   typedef enum logic [1:0] {
      LINE_RAW,
      LINE_TEMP,
      LINE_OVER
   } pct_kind_type;

   // job handed from the classifier to the decimal converter
   typedef struct packed {
      pct_kind_type kind;
      logic         neg;
      logic [31:0]  value;
   } pct_job_type;

   // decoded line waiting for the character sequencer; digits[0] is the ones place
   typedef struct packed {
      pct_kind_type    kind;
      logic            neg;
      logic [9:0][3:0] digits;
   } pct_line_type;

   // divide by 103: floor reciprocal, quotient low by at most one, fixed after
   localparam logic [6:0]  DIVISOR   = 7'd103;
   localparam logic [31:0] DIV_RECIP = 32'd2668717543;
   localparam int          DIV_SHIFT = 38;
   localparam int          QUOT_W    = 64 - DIV_SHIFT;

   // temperature segments, magnitude in 0.0001 C
   localparam int MAG_W = 20;
   localparam int SEG_N = 7;
   localparam logic [10:0] SEG_LO [SEG_N] =
      '{11'd1443, 11'd1284, 11'd1125, 11'd966, 11'd808, 11'd651, 11'd494};
   localparam logic [10:0] SEG_HI [SEG_N] =
      '{11'd1602, 11'd1443, 11'd1284, 11'd1125, 11'd966, 11'd808, 11'd651};
   localparam logic [9:0] SEG_COEF [SEG_N] =
      '{10'd629, 10'd629, 10'd629, 10'd629, 10'd633, 10'd637, 10'd637};
   localparam logic [MAG_W-1:0] SEG_BASE [SEG_N] =
      '{20'd400000, 20'd300000, 20'd200000, 20'd100000, 20'd0, 20'd100000, 20'd200000};
   localparam logic SEG_NEG [SEG_N] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1};

   // two binary bits per conversion step
   localparam int          BCD_STEPS = 16;
   localparam logic [3:0]  STEP_LAST = 4'(BCD_STEPS - 1);

   // character positions of the final character
   localparam logic [3:0] POS_LAST_SHORT = 4'd12;
   localparam logic [3:0] POS_LAST_OVER  = 4'd15;

   // ASCII
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_POINT = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_C     = 8'h43;
   localparam logic [7:0] CH_X     = 8'h78;

endpackage
`default_nettype wire

/* src/pct_classify.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pct_classify
// Front pipeline: accept, divide by 103, pick the temperature segment and
// form the value to print.
// ----------------------------------------------------------------------------
module pct_classify
   import pct_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire pct_req_type req_data,
   output logic             job_valid,
   input  wire logic        job_ready,
   output pct_job_type      job_data
);

   logic              advance;
   logic              v1_ff, v2_ff, v3_ff, job_valid_ff;
   logic              op1_ff, op2_ff, op3_ff;
   logic [31:0]       cnt1_ff, cnt2_ff, cnt3_ff;
   logic [QUOT_W-1:0] q2_ff, q3_ff;
   logic [QUOT_W-1:0] q2_in, q3_in;
   pct_job_type       job_ff, job_in;

   logic [63:0]       prod;
   logic [32:0]       q_times_div;
   logic [32:0]       rem;

   logic              hit;
   logic [9:0]        coef;
   logic [7:0]        off;
   logic [MAG_W-1:0]  base;
   logic              neg;
   logic [17:0]       scaled;
   logic [MAG_W-1:0]  mag;

   // whole pipe holds while the output job is stalled
   assign advance   = ~job_valid_ff | job_ready;
   assign req_ready = advance;
   assign job_valid = job_valid_ff;
   assign job_data  = job_ff;

   always_comb begin
      prod        = {32'd0, cnt1_ff} * {32'd0, DIV_RECIP};
      q2_in       = prod[63:DIV_SHIFT];
      q_times_div = 33'(q2_ff) * 33'(DIVISOR);
      rem         = {1'b0, cnt2_ff} - q_times_div;
      q3_in       = (rem >= 33'(DIVISOR)) ? q2_ff + 1'b1 : q2_ff;
   end

   always_comb begin
      hit  = 1'b0;
      coef = '0;
      off  = '0;
      base = '0;
      neg  = 1'b0;
      for (int i = 0; i < SEG_N; i++) begin
         if (q3_ff >= QUOT_W'(SEG_LO[i]) && q3_ff < QUOT_W'(SEG_HI[i])) begin
            hit  = 1'b1;
            coef = SEG_COEF[i];
            off  = 8'(q3_ff - QUOT_W'(SEG_LO[i]));
            base = SEG_BASE[i];
            neg  = SEG_NEG[i];
         end
      end
      scaled = {8'd0, coef} * {10'd0, off};
      mag    = neg ? base - MAG_W'(scaled) : base + MAG_W'(scaled);

      job_in.neg = 1'b0;
      if (op3_ff == OP_TEMP && hit) begin
         job_in.kind  = LINE_TEMP;
         job_in.neg   = neg;
         job_in.value = {{(32 - MAG_W){1'b0}}, mag};
      end else if (op3_ff == OP_TEMP) begin
         job_in.kind  = LINE_OVER;
         job_in.value = cnt3_ff;
      end else begin
         job_in.kind  = LINE_RAW;
         job_in.value = cnt3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         job_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= req_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         job_valid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         op1_ff  <= req_data.op;
         cnt1_ff <= req_data.pulse_count;
         op2_ff  <= op1_ff;
         cnt2_ff <= cnt1_ff;
         q2_ff   <= q2_in;
         op3_ff  <= op2_ff;
         cnt3_ff <= cnt2_ff;
         q3_ff   <= q3_in;
         job_ff  <= job_in;
      end
   end

endmodule
`default_nettype wire

/* src/pct_bcd.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pct_bcd
// Binary to ten-digit BCD converter, shift-and-add-3, two bits per cycle.
// ----------------------------------------------------------------------------
module pct_bcd
   import pct_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        job_valid,
   output logic             job_ready,
   input  wire pct_job_type job_data,
   output logic             line_valid,
   input  wire logic        line_ready,
   output pct_line_type     line_data
);

   function automatic logic [9:0][3:0] add3(input logic [9:0][3:0] d);
      logic [9:0][3:0] r;
      for (int k = 0; k < 10; k++) begin
         r[k] = (d[k] >= 4'd5) ? d[k] + 4'd3 : d[k];
      end
      return r;
   endfunction

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [3:0]      step_ff, step_in;
   logic [31:0]     bin_ff, bin_in;
   logic [9:0][3:0] bcd_ff, bcd_in;
   pct_kind_type    kind_ff, kind_in;
   logic            neg_ff, neg_in;
   logic [39:0]     t1, t2;
   logic            load;

   assign job_ready        = ~busy_ff & (~done_ff | line_ready);
   assign load             = job_valid & job_ready;
   assign line_valid       = done_ff;
   assign line_data.kind   = kind_ff;
   assign line_data.neg    = neg_ff;
   assign line_data.digits = bcd_ff;

   always_comb begin
      t1 = add3(bcd_ff);
      t1 = {t1[38:0], bin_ff[31]};
      t2 = add3(t1);
      t2 = {t2[38:0], bin_ff[30]};

      busy_in = busy_ff;
      done_in = done_ff;
      step_in = step_ff;
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      kind_in = kind_ff;
      neg_in  = neg_ff;
      if (load) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         step_in = '0;
         bin_in  = job_data.value;
         bcd_in  = '0;
         kind_in = job_data.kind;
         neg_in  = job_data.neg;
      end else if (busy_ff) begin
         bcd_in  = t2;
         bin_in  = {bin_ff[29:0], 2'b00};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (done_ff && line_ready) begin
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      kind_ff <= kind_in;
      neg_ff  <= neg_in;
   end

endmodule
`default_nettype wire

/* src/pct_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pct_queue
// Two-entry queue of decoded lines between the front and the back end.
// ----------------------------------------------------------------------------
module pct_queue
   import pct_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire pct_line_type in_data,
   output logic              out_valid,
   input  wire logic         out_ready,
   output pct_line_type      out_data
);

   pct_line_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid & in_ready;
   assign pop       = out_valid & out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule
`default_nettype wire

/* src/pct_emit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pct_emit
// Back end: walks one decoded line and sends it a character per transaction.
// ----------------------------------------------------------------------------
module pct_emit
   import pct_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         line_valid,
   output logic              line_ready,
   input  wire pct_line_type line_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output pct_rsp_type       rsp_data
);

   logic [3:0]  pos_ff, pos_in;
   logic        rsp_valid_ff, rsp_valid_in;
   pct_rsp_type rsp_ff, rsp_in;
   logic        load;
   logic        is_last;
   logic [3:0]  dig_idx;
   logic [3:0]  dig;
   logic [7:0]  dig_char;
   logic [7:0]  ch;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign load       = line_valid & (~rsp_valid_ff | rsp_ready);
   assign line_ready = load & is_last;

   always_comb begin
      is_last  = (line_data.kind == LINE_OVER) ? (pos_ff == POS_LAST_OVER)
                                               : (pos_ff == POS_LAST_SHORT);
      // temperature prints places 5..0, count prints places 9..0
      dig_idx  = (line_data.kind == LINE_TEMP) ? 4'd9 - pos_ff : 4'd11 - pos_ff;
      dig      = (dig_idx <= 4'd9) ? line_data.digits[dig_idx] : 4'd0;
      dig_char = CH_ZERO + {4'd0, dig};

      unique case (line_data.kind)
         LINE_TEMP: begin
            unique case (pos_ff)
               4'd0:    ch = CH_NL;
               4'd1:    ch = line_data.neg ? CH_MINUS : CH_PLUS;
               4'd2:    ch = CH_SPACE;
               4'd3:    ch = CH_ZERO + {4'd0, line_data.digits[5]};
               4'd4:    ch = CH_ZERO + {4'd0, line_data.digits[4]};
               4'd5:    ch = CH_POINT;
               4'd10:   ch = CH_SPACE;
               4'd11:   ch = CH_C;
               4'd12:   ch = CH_NL;
               default: ch = dig_char;
            endcase
         end
         LINE_OVER: begin
            unique case (pos_ff)
               4'd0:    ch = CH_NL;
               4'd1:    ch = CH_X;
               4'd12:   ch = CH_SPACE;
               4'd13:   ch = CH_C;
               4'd14:   ch = CH_NL;
               4'd15:   ch = CH_NL;
               default: ch = dig_char;
            endcase
         end
         default: begin
            unique case (pos_ff)
               4'd0:    ch = CH_NL;
               4'd1:    ch = CH_SPACE;
               4'd12:   ch = CH_NL;
               default: ch = dig_char;
            endcase
         end
      endcase

      pos_in       = pos_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (load) begin
         pos_in           = is_last ? 4'd0 : pos_ff + 1'b1;
         rsp_in.char_code = ch;
         rsp_in.last      = is_last;
         rsp_valid_in     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule
`default_nettype wire

/* src/pulse_count_temperature_ascii.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pulse_count_temperature_ascii
// Formats a sensor pulse count as an ASCII line: raw decimal count, or the
// count converted to a temperature in C.
//
//   channel   ports               payload        moves
//   request   req_valid/ready     pct_req_type   one count and mode
//   response  rsp_valid/ready     pct_rsp_type   one character, last flag
//
// A line is 13 characters, 16 when the temperature is out of range.
// Throughput is set by the decimal converter: it takes a new count only after
// its load and 16 two-bit steps, once its line is taken; the character back end runs in parallel.
// A count passes the classifier pipe, the converter and the queue before its first character.
// A two-line queue lets the front keep converting while the response stalls.
// Synchronous reset clears all control state; no clearing pass.
// ----------------------------------------------------------------------------
module pulse_count_temperature_ascii
   import pct_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire pct_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output pct_rsp_type      rsp_data
);

   logic         job_valid, job_ready;
   pct_job_type  job_data;
   logic         conv_valid, conv_ready;
   pct_line_type conv_data;
   logic         line_valid, line_ready;
   pct_line_type line_data;

   pct_classify u_classify (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job_data  (job_data)
   );

   pct_bcd u_bcd (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (job_valid),
      .job_ready  (job_ready),
      .job_data   (job_data),
      .line_valid (conv_valid),
      .line_ready (conv_ready),
      .line_data  (conv_data)
   );

   pct_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (conv_valid),
      .in_ready  (conv_ready),
      .in_data   (conv_data),
      .out_valid (line_valid),
      .out_ready (line_ready),
      .out_data  (line_data)
   );

   pct_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .line_valid (line_valid),
      .line_ready (line_ready),
      .line_data  (line_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire
